/* rtl/dtb_pkg.sv */
`default_nettype none

package dtb_pkg;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_HIT   = 2'd1,
        REQ_RESET = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        REG_TGT_SW   = 3'd0,
        REG_SOL_NUM  = 3'd1,
        REG_TGT_CNT  = 3'd2,
        REG_SOL_CNT  = 3'd3,
        REG_STRENGTH = 3'd4,
        REG_STAGGER  = 3'd5,
        REG_DURATION = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now;
        logic [7:0]  switch_number;
        logic [31:0] reset_at;
        logic [7:0]  switch_states;
    } in_item_t;

    typedef struct packed {
        logic        fire_valid;
        logic [7:0]  solenoid_number;
        logic [7:0]  fire_strength_out;
        logic [31:0] fire_time;
        logic        hit_accepted;
        logic        in_bank;
        logic        target_found;
        logic [2:0]  target_index;
        logic        bank_cleared;
        logic        reset_busy;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] target_switches;
        logic [63:0] solenoid_numbers;
        logic [3:0]  target_count;
        logic [3:0]  solenoid_count;
        logic [7:0]  fire_strength;
        logic [15:0] fire_stagger;
        logic [15:0] reset_duration;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/dtb_regs.sv */
`default_nettype none

module dtb_regs (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [dtb_pkg::ADDR_W-1:0]  paddr,
    input  wire [dtb_pkg::DATA_W-1:0]  pwdata,
    output logic [dtb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dtb_pkg::cfg_t              cfg
);

    localparam int ADDR_HI = dtb_pkg::ADDR_W - 1;

    localparam dtb_pkg::cfg_t CFG_RESET = '{
        target_switches:  64'd0,
        solenoid_numbers: 64'd0,
        target_count:     4'd1,
        solenoid_count:   4'd1,
        fire_strength:    8'd0,
        fire_stagger:     16'd0,
        reset_duration:   16'd0
    };

    dtb_pkg::cfg_t     cfg_reg;
    dtb_pkg::cfg_t     cfg_next;
    dtb_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = dtb_pkg::reg_idx_t'(paddr[ADDR_HI:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dtb_pkg::REG_TGT_SW:   cfg_next.target_switches  = pwdata;
                dtb_pkg::REG_SOL_NUM:  cfg_next.solenoid_numbers = pwdata;
                dtb_pkg::REG_TGT_CNT:  cfg_next.target_count     = pwdata[3:0];
                dtb_pkg::REG_SOL_CNT:  cfg_next.solenoid_count   = pwdata[3:0];
                dtb_pkg::REG_STRENGTH: cfg_next.fire_strength    = pwdata[7:0];
                dtb_pkg::REG_STAGGER:  cfg_next.fire_stagger     = pwdata[15:0];
                dtb_pkg::REG_DURATION: cfg_next.reset_duration   = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dtb_pkg::REG_TGT_SW:   prdata = cfg_reg.target_switches;
            dtb_pkg::REG_SOL_NUM:  prdata = cfg_reg.solenoid_numbers;
            dtb_pkg::REG_TGT_CNT:  prdata = 64'(cfg_reg.target_count);
            dtb_pkg::REG_SOL_CNT:  prdata = 64'(cfg_reg.solenoid_count);
            dtb_pkg::REG_STRENGTH: prdata = 64'(cfg_reg.fire_strength);
            dtb_pkg::REG_STAGGER:  prdata = 64'(cfg_reg.fire_stagger);
            dtb_pkg::REG_DURATION: prdata = 64'(cfg_reg.reset_duration);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/drop_target_bank_controller.sv */
`default_nettype none

// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | dtb_pkg::in_item_t
// rsp     | out       | rsp_valid / rsp_ready | dtb_pkg::out_item_t
// apb     | in        | psel/penable, pready  | 64-bit registers at 8*index
//
// One item enters per cycle unless rsp is stalled or a coil burst runs; an
// accepted item passes the item register, then rsp_reg, to reach rsp.
// A tick that fires N coils emits N results, one per cycle while rsp_ready
// is high, and holds the next item until the last result is loaded.
// rst_n clears hits, armed times, the item and output stages; registers go
// to their reset values. With rsp_ready low the result holds and the item
// register takes one more item before req_ready drops.

module drop_target_bank_controller #(
    parameter int MAX_TARGETS = 8,
    parameter int MAX_COILS   = 8,
    parameter int TIME_WIDTH  = 32
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        req_valid,
    output logic                       req_ready,
    input  dtb_pkg::in_item_t          req,
    output logic                       rsp_valid,
    input  wire                        rsp_ready,
    output dtb_pkg::out_item_t         rsp,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [dtb_pkg::ADDR_W-1:0]  paddr,
    input  wire [dtb_pkg::DATA_W-1:0]  pwdata,
    output logic [dtb_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int TCW = $clog2(MAX_TARGETS + 1);
    localparam int CCW = $clog2(MAX_COILS + 1);

    dtb_pkg::cfg_t cfg;

    dtb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item stage
    dtb_pkg::in_item_t item_reg;
    logic              item_valid_reg;
    logic              item_take;

    // block state
    logic [MAX_TARGETS-1:0] hit_reg, hit_next;
    logic [TIME_WIDTH-1:0]  pend_reg, pend_next;
    logic [TIME_WIDTH-1:0]  end_reg, end_next;
    logic                   resetting_reg, resetting_next;

    // output stage and coil burst
    dtb_pkg::out_item_t    rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  burst_active_reg, burst_active_next;
    logic [CCW-1:0]        burst_idx_reg, burst_idx_next;
    logic [CCW-1:0]        burst_nc_reg, burst_nc_next;
    logic [TIME_WIDTH-1:0] burst_time_reg, burst_time_next;
    logic                  burst_cleared_reg, burst_cleared_next;
    logic                  burst_busy_reg, burst_busy_next;
    logic                  out_load;

    // item processing
    logic [7:0]             tgt_byte [MAX_TARGETS];
    logic [7:0]             sol_byte [8];
    logic [TCW-1:0]         n_tgt;
    logic [CCW-1:0]         n_coil;
    logic [MAX_TARGETS-1:0] cmask;
    logic [MAX_TARGETS-1:0] match;
    logic [MAX_TARGETS-1:0] cand;
    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  at_t;
    logic [TIME_WIDTH-1:0]  stagger_t;
    logic [19:0]            stag_total;
    dtb_pkg::out_item_t     proc_res;
    logic                   proc_burst;
    logic                   proc_cleared;
    logic                   proc_busy;
    logic                   found;
    logic [2:0]             found_idx;
    logic                   cand_any;
    logic [2:0]             cand_idx;

    assign n_tgt  = (cfg.target_count > 4'(MAX_TARGETS)) ? TCW'(MAX_TARGETS)
                                                        : TCW'(cfg.target_count);
    assign n_coil = (cfg.solenoid_count > 4'(MAX_COILS)) ? CCW'(MAX_COILS)
                                                        : CCW'(cfg.solenoid_count);
    assign now_t     = TIME_WIDTH'(item_reg.now);
    assign at_t      = TIME_WIDTH'(item_reg.reset_at);
    assign stagger_t = TIME_WIDTH'(cfg.fire_stagger);
    assign stag_total = 20'(cfg.fire_stagger) * 20'(n_coil);

    always_comb
    begin
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            tgt_byte[i] = cfg.target_switches[8*i +: 8];
            cmask[i]    = (i < int'(n_tgt));
            match[i]    = cmask[i] && (tgt_byte[i] == item_reg.switch_number);
            cand[i]     = match[i] && !hit_reg[i];
        end
        for (int j = 0; j < 8; j++)
        begin
            sol_byte[j] = cfg.solenoid_numbers[8*j +: 8];
        end
    end

    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        cand_any  = 1'b0;
        cand_idx  = '0;
        for (int i = MAX_TARGETS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found     = 1'b1;
                found_idx = 3'(i);
            end
            if (cand[i])
            begin
                cand_any = 1'b1;
                cand_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        end_next       = end_reg;
        resetting_next = resetting_reg;
        proc_res       = '0;
        proc_burst     = 1'b0;
        case (item_reg.req_type)
            dtb_pkg::REQ_TICK:
            begin
                if ((pend_reg != '0) && (now_t > pend_reg))
                begin
                    pend_next = '0;
                    if (n_coil != '0)
                    begin
                        proc_res.fire_valid        = 1'b1;
                        proc_res.solenoid_number   = sol_byte[0];
                        proc_res.fire_strength_out = cfg.fire_strength;
                        proc_res.fire_time         = 32'(now_t);
                        proc_burst                 = (n_coil != CCW'(1));
                    end
                end
                else if (resetting_reg && (now_t > end_reg))
                begin
                    hit_next       = hit_reg & ~cmask;
                    resetting_next = 1'b0;
                    end_next       = '0;
                end
            end
            dtb_pkg::REQ_HIT:
            begin
                if ((end_reg == '0) && cand_any)
                begin
                    hit_next[cand_idx]    = 1'b1;
                    proc_res.hit_accepted = 1'b1;
                end
                proc_res.in_bank      = found;
                proc_res.target_found = found;
                proc_res.target_index = found_idx;
            end
            dtb_pkg::REQ_RESET:
            begin
                if ((item_reg.switch_states[MAX_TARGETS-1:0] & cmask) != '0)
                begin
                    pend_next      = at_t;
                    end_next       = TIME_WIDTH'(at_t + TIME_WIDTH'(stag_total)
                                     + TIME_WIDTH'(cfg.reset_duration));
                    resetting_next = 1'b1;
                end
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
        proc_cleared          = ((hit_next & cmask) == cmask);
        proc_busy             = resetting_next || (pend_next != '0);
        proc_res.bank_cleared = proc_cleared;
        proc_res.reset_busy   = proc_busy;
        proc_res.last         = !proc_burst;
    end

    assign out_load  = !rsp_valid_reg || rsp_ready;
    assign item_take = item_valid_reg && out_load && !burst_active_reg;
    assign req_ready = !item_valid_reg || item_take;

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        burst_active_next  = burst_active_reg;
        burst_idx_next     = burst_idx_reg;
        burst_nc_next      = burst_nc_reg;
        burst_time_next    = burst_time_reg;
        burst_cleared_next = burst_cleared_reg;
        burst_busy_next    = burst_busy_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b0;
        end
        if (burst_active_reg && out_load)
        begin
            rsp_valid_next             = 1'b1;
            rsp_next                   = '0;
            rsp_next.fire_valid        = 1'b1;
            rsp_next.solenoid_number   = sol_byte[3'(burst_idx_reg)];
            rsp_next.fire_strength_out = cfg.fire_strength;
            rsp_next.fire_time         = 32'(burst_time_reg);
            rsp_next.bank_cleared      = burst_cleared_reg;
            rsp_next.reset_busy        = burst_busy_reg;
            rsp_next.last              = (CCW'(burst_idx_reg + 1'b1) == burst_nc_reg);
            burst_active_next          = !rsp_next.last;
            burst_idx_next             = CCW'(burst_idx_reg + 1'b1);
            burst_time_next            = TIME_WIDTH'(burst_time_reg + stagger_t);
        end
        else if (item_take)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next           = proc_res;
            burst_active_next  = proc_burst;
            burst_idx_next     = CCW'(1);
            burst_nc_next      = n_coil;
            burst_time_next    = TIME_WIDTH'(now_t + stagger_t);
            burst_cleared_next = proc_cleared;
            burst_busy_next    = proc_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            burst_active_reg <= 1'b0;
            hit_reg          <= '0;
            pend_reg         <= '0;
            end_reg          <= '0;
            resetting_reg    <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                item_valid_reg <= req_valid;
            end
            rsp_valid_reg    <= rsp_valid_next;
            burst_active_reg <= burst_active_next;
            if (item_take)
            begin
                hit_reg       <= hit_next;
                pend_reg      <= pend_next;
                end_reg       <= end_next;
                resetting_reg <= resetting_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            item_reg <= req;
        end
        rsp_reg           <= rsp_next;
        burst_idx_reg     <= burst_idx_next;
        burst_nc_reg      <= burst_nc_next;
        burst_time_reg    <= burst_time_next;
        burst_cleared_reg <= burst_cleared_next;
        burst_busy_reg    <= burst_busy_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_burst_shows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg |-> (rsp_valid && rsp.fire_valid && !rsp.last))
        else $error("coil burst active without a pending fire result");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |=> rsp_valid)
        else $error("multi-result item broke off before its last result");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.fire_valid) |-> rsp.last)
        else $error("status result not flagged last");

    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.hit_accepted) |-> (rsp.target_found && rsp.in_bank))
        else $error("hit accepted without a matching target");

endmodule

`default_nettype wire
